>>> hdl/quadratic_root_solver_assert.svh
// ----------------------------------------------------------------------------
// quadratic_root_solver_assert.svh
// assertion macros shared by the checker of the quadratic root solver
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define QRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define QRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// types, widths and codes shared by the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W   = 16;
    localparam int ROOT_W   = 32;
    localparam int CTOL_W   = 8;
    localparam int DTOL_W   = 16;
    localparam int FRAC_SH  = 16;

    // discriminant b*b - 4ac, exact
    localparam int DISC_W   = 2 * COEF_W + 2;
    // square root of the positive discriminant scaled to Q16.16
    localparam int SQ_W     = (DISC_W - 1 + FRAC_SH + 1) / 2;
    localparam int RAD_W    = 2 * SQ_W;
    // numerators and denominators of the final divisions
    localparam int NUM_W    = COEF_W + 19;
    localparam int MAG_W    = NUM_W - 1;
    localparam int DSW      = COEF_W + 2;
    localparam int DEN_W    = DSW - 1;
    localparam int DIV_LAT  = MAG_W + 3;

    typedef enum logic [1:0] {
        ST_TWO  = 2'd0,
        ST_ONE  = 2'd1,
        ST_NONE = 2'd2,
        ST_ALL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_LIN  = 2'd1,
        K_DBL  = 2'd2,
        K_TWO  = 2'd3
    } kind_t;

    typedef enum logic {
        CFG_COEF_TOL = 1'b0,
        CFG_DISC_TOL = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic signed [COEF_W-1:0] coef_c;
    } coef_t;

    typedef struct packed {
        status_t                  status;
        logic signed [ROOT_W-1:0] root_first;
        logic signed [ROOT_W-1:0] root_second;
    } root_t;

    typedef struct packed {
        kind_t                    kind;
        status_t                  status;
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } front_t;

    function automatic logic [COEF_W-1:0] coef_mag(input logic signed [COEF_W-1:0] x);
        coef_mag = x[COEF_W-1] ? COEF_W'(-x) : COEF_W'(x);
    endfunction

endpackage

>>> hdl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// products, discriminant and case selection, four register stages
// ----------------------------------------------------------------------------
module qrs_front
    import qrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  coef_t             coef,
    input  logic [CTOL_W-1:0] coef_tol,
    input  logic [DTOL_W-1:0] disc_tol,
    output logic              out_valid,
    output front_t            info,
    output logic [RAD_W-1:0]  rad
);

    logic                       v1_reg, v2_reg, v3_reg, v4_reg;
    coef_t                      c1_reg, c2_reg, c3_reg;
    logic signed [2*COEF_W-1:0] bb_reg, bb_next;
    logic signed [2*COEF_W-1:0] ac_reg, ac_next;
    logic [2:0]                 z2_reg, z3_reg, z_next;
    logic signed [DISC_W-1:0]   disc_reg, disc_next;
    logic [DISC_W-1:0]          disc_mag;
    front_t                     info_reg, info_next;
    logic [RAD_W-1:0]           rad_reg, rad_next;

    always_comb
    begin
        bb_next = c1_reg.coef_b * c1_reg.coef_b;
        ac_next = c1_reg.coef_a * c1_reg.coef_c;
        z_next  = {coef_mag(c1_reg.coef_a) <= COEF_W'(coef_tol),
                   coef_mag(c1_reg.coef_b) <= COEF_W'(coef_tol),
                   coef_mag(c1_reg.coef_c) <= COEF_W'(coef_tol)};
        disc_next = DISC_W'(bb_reg) - (DISC_W'(ac_reg) <<< 2);
    end

    // case selection: z3 bits are {a, b, c} near zero
    always_comb
    begin
        disc_mag       = disc_reg[DISC_W-1] ? DISC_W'(-disc_reg) : DISC_W'(disc_reg);
        info_next.a    = c3_reg.coef_a;
        info_next.b    = c3_reg.coef_b;
        info_next.c    = c3_reg.coef_c;
        info_next.kind = K_NONE;
        info_next.status = ST_NONE;
        rad_next       = '0;
        if (z3_reg[2])
        begin
            if (z3_reg[1])
            begin
                info_next.status = z3_reg[0] ? ST_ALL : ST_NONE;
            end
            else
            begin
                info_next.kind   = K_LIN;
                info_next.status = ST_ONE;
            end
        end
        else if (disc_mag <= DISC_W'(disc_tol))
        begin
            info_next.kind   = K_DBL;
            info_next.status = ST_ONE;
        end
        else if (disc_reg[DISC_W-1])
        begin
            info_next.status = ST_NONE;
        end
        else
        begin
            info_next.kind   = K_TWO;
            info_next.status = ST_TWO;
            rad_next         = RAD_W'({disc_reg[DISC_W-2:0], {FRAC_SH{1'b0}}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg   <= coef;
            c2_reg   <= c1_reg;
            bb_reg   <= bb_next;
            ac_reg   <= ac_next;
            z2_reg   <= z_next;
            c3_reg   <= c2_reg;
            z3_reg   <= z2_reg;
            disc_reg <= disc_next;
            info_reg <= info_next;
            rad_reg  <= rad_next;
        end
    end

    assign out_valid = v4_reg;
    assign info      = info_reg;
    assign rad       = rad_reg;

endmodule

>>> hdl/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined integer square root, one result bit per register stage
// ----------------------------------------------------------------------------
module qrs_sqrt
    import qrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  front_t           in_info,
    input  logic [RAD_W-1:0] rad,
    output logic             out_valid,
    output front_t           out_info,
    output logic [SQ_W-1:0]  root
);

    localparam int REM_W = SQ_W + 3;

    logic             vld_reg  [SQ_W];
    front_t           info_reg [SQ_W];
    logic [RAD_W-1:0] rad_reg  [SQ_W];
    logic [REM_W-1:0] rem_reg  [SQ_W];
    logic [SQ_W-1:0]  root_reg [SQ_W];

    for (genvar k = 0; k < SQ_W; k++)
    begin : g_step
        logic             vld_src;
        front_t           info_src;
        logic [RAD_W-1:0] rad_src;
        logic [REM_W-1:0] rem_src, rem_cat, trial, rem_next;
        logic [SQ_W-1:0]  root_src, root_next;

        if (k == 0)
        begin : g_first
            assign vld_src  = in_valid;
            assign info_src = in_info;
            assign rad_src  = rad;
            assign rem_src  = '0;
            assign root_src = '0;
        end
        else
        begin : g_rest
            assign vld_src  = vld_reg[k-1];
            assign info_src = info_reg[k-1];
            assign rad_src  = rad_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign root_src = root_reg[k-1];
        end

        always_comb
        begin
            rem_cat = {rem_src[REM_W-3:0], rad_src[RAD_W-1 -: 2]};
            trial   = REM_W'({root_src, 2'b01});
            if (rem_cat >= trial)
            begin
                rem_next  = rem_cat - trial;
                root_next = {root_src[SQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_cat;
                root_next = {root_src[SQ_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                info_reg[k] <= info_src;
                rad_reg[k]  <= {rad_src[RAD_W-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
            end
        end
    end

    assign out_valid = vld_reg[SQ_W-1];
    assign out_info  = info_reg[SQ_W-1];
    assign root      = root_reg[SQ_W-1];

endmodule

>>> hdl/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// pipelined signed division, rounded to nearest and saturated to a root
// ----------------------------------------------------------------------------
module qrs_div
    import qrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     adv,
    input  logic signed [NUM_W-1:0]  num,
    input  logic signed [DSW-1:0]    den,
    output logic signed [ROOT_W-1:0] quot
);

    localparam logic [MAG_W:0] HALF = (MAG_W+1)'(1) << (ROOT_W - 1);

    logic [MAG_W-1:0] n_reg   [MAG_W+1];
    logic [DEN_W-1:0] d_reg   [MAG_W+1];
    logic [DEN_W-1:0] rem_reg [MAG_W+1];
    logic [MAG_W-1:0] q_reg   [MAG_W+1];
    logic             neg_reg [MAG_W+1];

    logic [MAG_W:0]          qr_reg;
    logic                    rneg_reg;
    logic [MAG_W:0]          qr_next, qsat;
    logic signed [ROOT_W-1:0] quot_reg, quot_next;

    // magnitudes and sign
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg[0]   <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
            d_reg[0]   <= den[DSW-1] ? DEN_W'(-den) : DEN_W'(den);
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1] ^ den[DSW-1];
        end
    end

    for (genvar k = 0; k < MAG_W; k++)
    begin : g_step
        logic [DEN_W:0]   rem_cat;
        logic [DEN_W-1:0] rem_next;
        logic             bit_q;

        always_comb
        begin
            rem_cat = {rem_reg[k], n_reg[k][MAG_W-1]};
            bit_q   = rem_cat >= {1'b0, d_reg[k]};
            rem_next = bit_q ? DEN_W'(rem_cat - {1'b0, d_reg[k]}) : DEN_W'(rem_cat);
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                n_reg[k+1]   <= {n_reg[k][MAG_W-2:0], 1'b0};
                d_reg[k+1]   <= d_reg[k];
                rem_reg[k+1] <= rem_next;
                q_reg[k+1]   <= {q_reg[k][MAG_W-2:0], bit_q};
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // round half away from zero: bump when twice the remainder reaches the divisor
    always_comb
    begin
        qr_next = (MAG_W+1)'(q_reg[MAG_W])
                + (MAG_W+1)'({rem_reg[MAG_W], 1'b0} >= {1'b0, d_reg[MAG_W]});
        if (rneg_reg)
        begin
            qsat      = (qr_reg > HALF) ? HALF : qr_reg;
            quot_next = ROOT_W'(-qsat);
        end
        else
        begin
            qsat      = (qr_reg > HALF - 1'b1) ? HALF - 1'b1 : qr_reg;
            quot_next = ROOT_W'(qsat);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qr_reg   <= qr_next;
            rneg_reg <= neg_reg[MAG_W];
            quot_reg <= quot_next;
        end
    end

    assign quot = quot_reg;

endmodule

>>> hdl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2 + b*x + c, Q8.8 coefficients in, Q16.16 roots out
// ----------------------------------------------------------------------------
// Fully pipelined: one coefficient beat is taken every cycle and each gives
// one result beat after the products, discriminant and case selection, 25
// square-root stages, 1 numerator stage and the two parallel rounding
// dividers. The whole pipe holds while a finished result is stalled at the
// output; coef_stall then follows root_stall. Tolerance registers are
// written through the cfg port, always ready.
// ----------------------------------------------------------------------------
module quadratic_root_solver
    import qrs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              coef_valid,
    output logic              coef_stall,
    input  coef_t             coef,
    output logic              root_valid,
    input  logic              root_stall,
    output root_t             root,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  cfg_idx_t          cfg_index,
    input  logic [DTOL_W-1:0] cfg_data
);

    logic              adv;
    logic [CTOL_W-1:0] coef_tol_reg;
    logic [DTOL_W-1:0] disc_tol_reg;

    logic              fr_valid;
    front_t            fr_info;
    logic [RAD_W-1:0]  fr_rad;
    logic              sq_valid;
    front_t            sq_info;
    logic [SQ_W-1:0]   sq_root;

    logic                    num_vld_reg;
    status_t                 num_status_reg;
    logic signed [NUM_W-1:0] n1_reg, n1_next, n2_reg, n2_next, nb_x, s_x;
    logic signed [DSW-1:0]   d_reg, d_next;

    logic    tag_vld_reg    [DIV_LAT];
    status_t tag_status_reg [DIV_LAT];

    logic signed [ROOT_W-1:0] q1, q2;

    assign adv        = !(root_valid && root_stall);
    assign coef_stall = !adv;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_tol_reg <= CTOL_W'(1);
            disc_tol_reg <= DTOL_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COEF_TOL: coef_tol_reg <= cfg_data[CTOL_W-1:0];
                CFG_DISC_TOL: disc_tol_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (coef_valid),
        .coef      (coef),
        .coef_tol  (coef_tol_reg),
        .disc_tol  (disc_tol_reg),
        .out_valid (fr_valid),
        .info      (fr_info),
        .rad       (fr_rad)
    );

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_info   (fr_info),
        .rad       (fr_rad),
        .out_valid (sq_valid),
        .out_info  (sq_info),
        .root      (sq_root)
    );

    // numerators and denominator; unused roots get a zero numerator
    always_comb
    begin
        nb_x    = -(NUM_W'(sq_info.b) <<< 8);
        s_x     = NUM_W'(sq_root);
        n1_next = '0;
        n2_next = '0;
        d_next  = DSW'(1);
        case (sq_info.kind)
            K_LIN:
            begin
                n1_next = -(NUM_W'(sq_info.c) <<< FRAC_SH);
                d_next  = DSW'(sq_info.b);
            end
            K_DBL:
            begin
                n1_next = -(NUM_W'(sq_info.b) <<< FRAC_SH);
                d_next  = DSW'(sq_info.a) <<< 1;
            end
            K_TWO:
            begin
                n1_next = (nb_x - s_x) <<< 8;
                n2_next = (nb_x + s_x) <<< 8;
                d_next  = DSW'(sq_info.a) <<< 1;
            end
            default:
            begin
                n1_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            num_vld_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_status_reg <= sq_info.status;
            n1_reg         <= n1_next;
            n2_reg         <= n2_next;
            d_reg          <= d_next;
        end
    end

    qrs_div u_div_first (
        .clk  (clk),
        .adv  (adv),
        .num  (n1_reg),
        .den  (d_reg),
        .quot (q1)
    );

    qrs_div u_div_second (
        .clk  (clk),
        .adv  (adv),
        .num  (n2_reg),
        .den  (d_reg),
        .quot (q2)
    );

    // valid and status ride alongside the dividers
    for (genvar k = 0; k < DIV_LAT; k++)
    begin : g_tag
        logic    vld_src;
        status_t st_src;

        if (k == 0)
        begin : g_first
            assign vld_src = num_vld_reg;
            assign st_src  = num_status_reg;
        end
        else
        begin : g_rest
            assign vld_src = tag_vld_reg[k-1];
            assign st_src  = tag_status_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                tag_vld_reg[k] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                tag_status_reg[k] <= st_src;
            end
        end
    end

    assign root_valid       = tag_vld_reg[DIV_LAT-1];
    assign root.status      = tag_status_reg[DIV_LAT-1];
    assign root.root_first  = q1;
    assign root.root_second = q2;

endmodule

>>> hdl/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker
// port-level checks on the quadratic root solver, bound to the top level
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_assert.svh"

module qrs_checker
    import qrs_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  coef_stall,
    input logic  root_valid,
    input logic  root_stall,
    input root_t root,
    input logic  cfg_valid,
    input logic  cfg_ready
);

    `QRS_ASSERT_NEXT(a_out_hold, root_valid && root_stall, root_valid && $stable(root), "stalled result beat changed")
    `QRS_ASSERT_NOW(a_in_stall_cause, coef_stall, root_valid && root_stall, "input stalled without an output stall")
    `QRS_ASSERT_NOW(a_no_root_zero, root_valid && (root.status == ST_NONE || root.status == ST_ALL), root.root_first == '0 && root.root_second == '0, "roots not zero without a single solution")
    `QRS_ASSERT_NOW(a_one_root, root_valid && root.status == ST_ONE, root.root_second == '0, "second root not zero for a single root")
    `QRS_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);
